[rtl/core/fbfla_pkg.sv]
package fbfla_pkg;

    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SMALL = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_POP   = 2'd1,
        S_CARVE = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP         = 3'd0,
        DP_PUSH        = 3'd1,
        DP_POP         = 3'd2,
        DP_CARVE_START = 3'd3,
        DP_CARVE_STEP  = 3'd4
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    res_valid;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic hold_valid;
        logic head_null;
        logic pool_full;
        logic size_small;
        logic carve_last;
    } t_dp_stat;

endpackage

[rtl/core/fbfla_ctrl.sv]
module fbfla_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    input  fbfla_pkg::t_dp_stat i_stat,
    output logic                o_in_ready,
    output fbfla_pkg::t_dp_cmd  o_cmd
);

    fbfla_pkg::t_state r_state;
    fbfla_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.op         = fbfla_pkg::DP_NOP;
        o_cmd.res_valid  = 1'b0;
        o_cmd.res_status = fbfla_pkg::STATUS_OK;
        unique case (r_state)
            fbfla_pkg::S_IDLE: begin
                // a result still parked in the hold stage blocks new words
                o_in_ready = !i_stat.hold_valid;
                if (i_in_valid && !i_stat.hold_valid) begin
                    priority if (i_req_type == fbfla_pkg::REQ_FREE) begin
                        o_cmd.op        = fbfla_pkg::DP_PUSH;
                        o_cmd.res_valid = 1'b1;
                    end else if (i_stat.size_small) begin
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = fbfla_pkg::STATUS_TOO_SMALL;
                    end else if (!i_stat.head_null) begin
                        // link of the head is being read this cycle
                        n_state = fbfla_pkg::S_POP;
                    end else if (i_stat.pool_full) begin
                        o_cmd.res_valid  = 1'b1;
                        o_cmd.res_status = fbfla_pkg::STATUS_EXHAUSTED;
                    end else begin
                        // first slot of the new chunk is granted right away
                        o_cmd.op        = fbfla_pkg::DP_CARVE_START;
                        o_cmd.res_valid = 1'b1;
                        n_state         = fbfla_pkg::S_CARVE;
                    end
                end
            end
            fbfla_pkg::S_POP: begin
                o_cmd.op        = fbfla_pkg::DP_POP;
                o_cmd.res_valid = 1'b1;
                n_state         = fbfla_pkg::S_IDLE;
            end
            fbfla_pkg::S_CARVE: begin
                o_cmd.op = fbfla_pkg::DP_CARVE_STEP;
                if (i_stat.carve_last) begin
                    n_state = fbfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbfla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/fbfla_datapath.sv]
module fbfla_datapath #(
    parameter int CHUNK_SLOTS     = 5,
    parameter int MAX_CHUNKS      = 8,
    parameter int MIN_BLOCK_BYTES = 8,
    localparam int POOL_SLOTS     = CHUNK_SLOTS * MAX_CHUNKS,
    localparam int SLOT_W         = $clog2(POOL_SLOTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbfla_pkg::t_dp_cmd            i_cmd,
    output fbfla_pkg::t_dp_stat           o_stat,
    input  logic [fbfla_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [SLOT_W-1:0]             i_slot,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output fbfla_pkg::t_status            o_out_status,
    output logic [SLOT_W-1:0]             o_out_slot
);

    localparam int ADDR_W   = $clog2(POOL_SLOTS);
    localparam int CARVED_W = $clog2(MAX_CHUNKS + 1);
    localparam int LEFT_W   = $clog2(CHUNK_SLOTS);
    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(POOL_SLOTS);

    logic [SLOT_W-1:0]   r_link_mem [POOL_SLOTS];
    logic [SLOT_W-1:0]   r_link_rd;

    logic [SLOT_W-1:0]   r_head;
    logic [SLOT_W-1:0]   n_head;
    logic [SLOT_W-1:0]   r_base;
    logic [SLOT_W-1:0]   n_base;
    logic [CARVED_W-1:0] r_carved;
    logic [CARVED_W-1:0] n_carved;
    logic [SLOT_W-1:0]   r_carve_addr;
    logic [SLOT_W-1:0]   n_carve_addr;
    logic [LEFT_W-1:0]   r_carve_left;
    logic [LEFT_W-1:0]   n_carve_left;

    logic                r_out_valid;
    logic                n_out_valid;
    fbfla_pkg::t_status  r_out_status;
    fbfla_pkg::t_status  n_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [SLOT_W-1:0]   n_out_slot;
    logic                r_hold_valid;
    logic                n_hold_valid;
    fbfla_pkg::t_status  r_hold_status;
    fbfla_pkg::t_status  n_hold_status;
    logic [SLOT_W-1:0]   r_hold_slot;
    logic [SLOT_W-1:0]   n_hold_slot;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   wr_data;
    logic [SLOT_W-1:0]   res_slot;
    logic                out_free;

    assign o_stat.hold_valid = r_hold_valid;
    assign o_stat.head_null  = (r_head == NULL_SLOT);
    assign o_stat.pool_full  = (r_carved == CARVED_W'(MAX_CHUNKS));
    assign o_stat.size_small = (i_req_size < fbfla_pkg::SIZE_W'(MIN_BLOCK_BYTES));
    assign o_stat.carve_last = (r_carve_left == '0);

    // link store write port: free pushes and chunk link-up share it
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_slot[ADDR_W-1:0];
        wr_data = r_head;
        unique case (i_cmd.op)
            fbfla_pkg::DP_PUSH: begin
                wr_en = (i_slot < NULL_SLOT);
            end
            fbfla_pkg::DP_CARVE_STEP: begin
                wr_en   = 1'b1;
                wr_addr = r_carve_addr[ADDR_W-1:0];
                wr_data = (r_carve_left == '0) ? NULL_SLOT : r_carve_addr + SLOT_W'(1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // head link is read every cycle; used only in the cycle after an accept
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        r_link_rd <= r_link_mem[r_head[ADDR_W-1:0]];
    end

    always_comb begin
        n_head       = r_head;
        n_base       = r_base;
        n_carved     = r_carved;
        n_carve_addr = r_carve_addr;
        n_carve_left = r_carve_left;
        res_slot     = '0;
        unique case (i_cmd.op)
            fbfla_pkg::DP_PUSH: begin
                if (i_slot < NULL_SLOT) begin
                    n_head = i_slot;
                end
            end
            fbfla_pkg::DP_POP: begin
                res_slot = r_head;
                n_head   = r_link_rd;
            end
            fbfla_pkg::DP_CARVE_START: begin
                // base slot goes out now, the rest is linked from base + 1
                res_slot     = r_base;
                n_head       = r_base + SLOT_W'(1);
                n_carve_addr = r_base + SLOT_W'(1);
                n_carve_left = LEFT_W'(CHUNK_SLOTS - 2);
                n_base       = r_base + SLOT_W'(CHUNK_SLOTS);
                n_carved     = r_carved + CARVED_W'(1);
            end
            fbfla_pkg::DP_CARVE_STEP: begin
                n_carve_addr = r_carve_addr + SLOT_W'(1);
                n_carve_left = r_carve_left - LEFT_W'(1);
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    // output register with a one-word hold stage behind it
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_hold_valid  = r_hold_valid;
        n_hold_status = r_hold_status;
        n_hold_slot   = r_hold_slot;
        if (out_free) begin
            if (r_hold_valid) begin
                n_out_valid  = 1'b1;
                n_out_status = r_hold_status;
                n_out_slot   = r_hold_slot;
                n_hold_valid = 1'b0;
            end else if (i_cmd.res_valid) begin
                n_out_valid  = 1'b1;
                n_out_status = i_cmd.res_status;
                n_out_slot   = res_slot;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_cmd.res_valid) begin
            n_hold_valid  = 1'b1;
            n_hold_status = i_cmd.res_status;
            n_hold_slot   = res_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= NULL_SLOT;
            r_base       <= '0;
            r_carved     <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_base       <= n_base;
            r_carved     <= n_carved;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carve_addr  <= n_carve_addr;
        r_carve_left  <= n_carve_left;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_hold_status <= n_hold_status;
        r_hold_slot   <= n_hold_slot;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// Fixed-size slot allocator: CHUNK_SLOTS * MAX_CHUNKS slots handed out from a LIFO
// free list whose links live in a link memory indexed by slot, with one read and one
// write port. Each request word gives exactly one response word. A free, a too-small
// request and an exhausted pool are handled in the idle state; an allocate from a
// non-empty list also passes through the pop state because the link of the head
// comes out of the registered memory read. An allocate on an empty list grants the
// first slot of a new chunk at once, then holds off input while the chunk's
// CHUNK_SLOTS - 1 links are written, one per cycle through the memory's one write
// port. Responses sit in an output register backed by a one-word hold stage, so a
// stalled consumer stops intake only once both are full.
// Slot indexes at or above the pool size are ignored on free; no double-free check.
module fixed_block_free_list_allocator #(
    parameter int CHUNK_SLOTS     = 5,
    parameter int MAX_CHUNKS      = 8,
    parameter int MIN_BLOCK_BYTES = 8,
    localparam int POOL_SLOTS     = CHUNK_SLOTS * MAX_CHUNKS,
    localparam int SLOT_W         = $clog2(POOL_SLOTS + 1),
    localparam int IN_DATA_W      = ((fbfla_pkg::SIZE_W + SLOT_W + 7) / 8) * 8,
    localparam int OUT_DATA_W     = ((fbfla_pkg::STATUS_W + SLOT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] request_size, next SLOT_W bits slot_index, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] req_type
    input  logic [0:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] status, next SLOT_W bits granted_slot, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    fbfla_pkg::t_dp_cmd  dp_cmd;
    fbfla_pkg::t_dp_stat dp_stat;
    fbfla_pkg::t_status  out_status;
    logic [SLOT_W-1:0]   out_slot;

    fbfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser[0]),
        .i_stat     (dp_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    fbfla_datapath #(
        .CHUNK_SLOTS     (CHUNK_SLOTS),
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_req_size   (i_s_axis_tdata[fbfla_pkg::SIZE_W-1:0]),
        .i_slot       (i_s_axis_tdata[fbfla_pkg::SIZE_W +: SLOT_W]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (out_status),
        .o_out_slot   (out_slot)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({out_slot, out_status});

endmodule
